// ===== src/sers_pkg.sv =====
// Shared constants and types for the sorted equal-range search block.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps

package sers_pkg;

    // Element store geometry
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths of the words on the two channels
    localparam int VALUE_W = 32;
    localparam int IDX_W   = 10;

    // Operation codes on the request channel
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Half-open search window [lo, hi) of one binary search
    typedef struct packed {
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
    } span_t;

endpackage

// ===== src/sers_req_if.sv =====
// Request channel: one load or search word with valid/ready handshake.
// Depends on sers_pkg for field widths.
`timescale 1ns / 1ps

interface sers_req_if
    import sers_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic signed [VALUE_W-1:0] value;
    logic                      last_element;

    modport source (output valid, output op, output value, output last_element,
                    input ready);
    modport sink   (input valid, input op, input value, input last_element,
                    output ready);
endinterface

// ===== src/sers_rsp_if.sv =====
// Response channel: one search result word with valid/ready handshake.
// Depends on sers_pkg for field widths.
`timescale 1ns / 1ps

interface sers_rsp_if
    import sers_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;

    modport source (output valid, output found, output first_index, output last_index,
                    input ready);
    modport sink   (input valid, input found, input first_index, input last_index,
                    output ready);
endinterface

// ===== src/sers_probe.sv =====
// Shared probe unit: one binary-search step, used by both bound searches.
// Depends on sers_pkg for the span type and widths.
`timescale 1ns / 1ps

module sers_probe
    import sers_pkg::*;
(
    input  span_t                     span,
    input  logic signed [VALUE_W-1:0] element,
    input  logic signed [VALUE_W-1:0] target,
    input  logic                      upper,
    output logic                      done,
    output span_t                     span_next
);

    logic [CNT_W-1:0] mid;
    logic             go_right;

    // Midpoint of the current window
    assign mid = span.lo + ((span.hi - span.lo) >> 1);

    // Lower bound moves right past smaller elements, upper bound also past equal ones
    assign go_right = upper ? (element <= target) : (element < target);

    assign done = (span.lo >= span.hi);

    // Narrow the window to one half
    always_comb
    begin
        if (go_right)
        begin
            span_next.lo = mid + CNT_W'(1);
            span_next.hi = span.hi;
        end
        else
        begin
            span_next.lo = span.lo;
            span_next.hi = mid;
        end
    end

endmodule

// ===== src/sorted_equal_range_search.sv =====
// Sorted equal-range search: a search runs a lower-bound and then an upper-bound
// binary search with one store read per probe, through the single probe unit and
// the single read port of the element store, then a hit check at the lower bound.
// One word is in work at a time; a finished result waits in the output register.
// Reset (rst_n, async, active low) clears the state, element count, open-load flag and
// output valid; the element store is not cleared, and reads past the count never decide a result.
`timescale 1ns / 1ps

module sorted_equal_range_search
    import sers_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sers_req_if.sink    req,
    sers_rsp_if.source  rsp
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOWER = 2'd1;
    localparam logic [1:0] ST_UPPER = 2'd2;
    localparam logic [1:0] ST_CHECK = 2'd3;

    logic signed [VALUE_W-1:0] store [DEPTH];

    logic [1:0]                state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      open_reg, open_next;
    span_t                     span_reg, span_next;
    logic [CNT_W-1:0]          lower_reg, lower_next;
    logic [CNT_W-1:0]          upper_reg, upper_next;
    logic signed [VALUE_W-1:0] target_reg, target_next;
    logic signed [VALUE_W-1:0] rd_data_reg;

    logic                      out_valid_reg, out_valid_next;
    logic                      found_reg, found_next;
    logic [IDX_W-1:0]          first_reg, first_next;
    logic [IDX_W-1:0]          last_reg, last_next;

    logic                      req_fire;
    logic                      load_fire;
    logic [CNT_W-1:0]          load_base;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic                      rd_en;
    logic [CNT_W-1:0]          rd_ptr;

    logic                      probe_done;
    span_t                     probe_span;
    logic                      hit;
    logic [CNT_W-1:0]          last_pos;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign load_fire = req_fire && (req.op == OP_LOAD);

    // Load slot: restart at zero when no array is open, drop once full
    assign load_base = open_reg ? count_reg : '0;
    assign wr_en     = load_fire && (load_base < CNT_W'(DEPTH));
    assign wr_addr   = load_base[ADDR_W-1:0];

    // Shared probe step for both bound searches
    sers_probe u_probe (
        .span      (span_reg),
        .element   (rd_data_reg),
        .target    (target_reg),
        .upper     (state_reg == ST_UPPER),
        .done      (probe_done),
        .span_next (probe_span)
    );

    assign hit      = (lower_reg < count_reg) && (rd_data_reg == target_reg);
    assign last_pos = (upper_reg > lower_reg) ? upper_reg - CNT_W'(1) : lower_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        open_next      = open_reg;
        span_next      = span_reg;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        target_next    = target_reg;
        rd_en          = 1'b0;
        rd_ptr         = span_reg.lo + ((span_reg.hi - span_reg.lo) >> 1);
        out_valid_next = out_valid_reg && !rsp.ready;
        found_next     = found_reg;
        first_next     = first_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.op == OP_LOAD)
                    begin
                        count_next = wr_en ? load_base + CNT_W'(1) : load_base;
                        open_next  = !req.last_element;
                    end
                    else
                    begin
                        // Open the lower-bound window and fetch its first probe
                        target_next  = req.value;
                        span_next.lo = '0;
                        span_next.hi = count_reg;
                        rd_ptr       = count_reg >> 1;
                        rd_en        = 1'b1;
                        state_next   = ST_LOWER;
                    end
                end
            end
            ST_LOWER:
            begin
                rd_en = 1'b1;
                if (probe_done)
                begin
                    // Keep lower bound, restart window for the upper bound
                    lower_next   = span_reg.lo;
                    span_next.lo = '0;
                    span_next.hi = count_reg;
                    rd_ptr       = count_reg >> 1;
                    state_next   = ST_UPPER;
                end
                else
                begin
                    span_next = probe_span;
                    rd_ptr    = probe_span.lo + ((probe_span.hi - probe_span.lo) >> 1);
                end
            end
            ST_UPPER:
            begin
                rd_en = 1'b1;
                if (probe_done)
                begin
                    // Fetch the element at the lower bound for the hit test
                    upper_next = span_reg.lo;
                    rd_ptr     = lower_reg;
                    state_next = ST_CHECK;
                end
                else
                begin
                    span_next = probe_span;
                    rd_ptr    = probe_span.lo + ((probe_span.hi - probe_span.lo) >> 1);
                end
            end
            ST_CHECK:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit;
                    first_next     = hit ? lower_reg[IDX_W-1:0] : '0;
                    last_next      = hit ? last_pos[IDX_W-1:0] : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Element store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[wr_addr] <= req.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= store[rd_ptr[ADDR_W-1:0]];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and search registers
    always_ff @(posedge clk)
    begin
        span_reg   <= span_next;
        lower_reg  <= lower_next;
        upper_reg  <= upper_next;
        target_reg <= target_next;
        found_reg  <= found_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = found_reg;
    assign rsp.first_index = first_reg;
    assign rsp.last_index  = last_reg;

endmodule
